[rtl/wbss_pkg.sv]
// Shared constants, types and helpers of the wildcard byte signature search.
package wbss_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned OffsetBits = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned PatBits    = 8 * MaxPattern;
  localparam int unsigned PosW       = $clog2(MaxPattern);

  // Register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] RegPat0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegPat1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegPat2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPat3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMask = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLen  = 3'd5;

  // Per-cell view of the signature, already aligned to the window position
  typedef struct packed {
    logic [7:0] pat;
    logic       wild;
    logic       used;
  } cell_cfg_t;

  // Clamp the length register to 1..MaxPattern
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len);
    logic [LenW-1:0] r;
    r = len;
    if (len == '0) begin
      r = LenW'(1);
    end else if (len > LenW'(MaxPattern)) begin
      r = LenW'(MaxPattern);
    end
    return r;
  endfunction

endpackage

[rtl/wbss_cfg.sv]
// Configuration registers and per-cell alignment of the signature.
module wbss_cfg
  import wbss_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [CfgDataW-1:0]    cfg_data_i,
  output cell_cfg_t              cell_cfg_o [MaxPattern],
  output logic [LenW-1:0]        len_o
);

  logic [PatBits-1:0]    pat_q;
  logic [MaxPattern-1:0] mask_q;
  logic [LenW-1:0]       len_q;
  logic [LenW-1:0]       len_eff;
  logic [LenW-1:0]       pos [MaxPattern];

  // Register writes; unknown indexes fall through
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q  <= '0;
      mask_q <= '0;
      len_q  <= LenW'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegPat0: pat_q[0*CfgDataW +: CfgDataW] <= cfg_data_i;
        RegPat1: pat_q[1*CfgDataW +: CfgDataW] <= cfg_data_i;
        RegPat2: pat_q[2*CfgDataW +: CfgDataW] <= cfg_data_i;
        RegPat3: pat_q[3*CfgDataW +: CfgDataW] <= cfg_data_i;
        RegMask: mask_q <= cfg_data_i[MaxPattern-1:0];
        RegLen:  len_q  <= cfg_data_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = eff_len(len_q);
  assign len_o   = len_eff;

  // Window cell k (k = 0 newest) faces pattern byte len-1-k
  always_comb begin
    for (int k = 0; k < MaxPattern; k++) begin
      pos[k]              = len_eff - LenW'(1) - LenW'(k);
      cell_cfg_o[k].used  = LenW'(k) < len_eff;
      cell_cfg_o[k].pat   = pat_q[8*pos[k][PosW-1:0] +: 8];
      cell_cfg_o[k].wild  = mask_q[pos[k][PosW-1:0]];
    end
  end

endmodule

[rtl/wbss_cell.sv]
// One window cell: holds a byte and its in-image flag, compares against its pattern byte.
module wbss_cell
  import wbss_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       shift_i,
  input  logic       clear_i,
  input  logic [7:0] byte_i,
  input  logic       valid_i,
  input  cell_cfg_t  cfg_i,
  output logic [7:0] byte_o,
  output logic       valid_o,
  output logic       ok_o
);

  logic [7:0] byte_q;
  logic       valid_q;
  logic       valid_d;

  // Payload byte moves on every accepted beat
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      byte_q <= byte_i;
    end
  end

  // In-image flag; dropped at the end of an image
  always_comb begin
    valid_d = valid_q;
    if (shift_i) begin
      valid_d = clear_i ? 1'b0 : valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Compare on the value this cell takes in with the current beat
  assign ok_o    = !cfg_i.used || (valid_i && (cfg_i.wild || (byte_i == cfg_i.pat)));
  assign byte_o  = byte_q;
  assign valid_o = valid_q;

endmodule

[rtl/wildcard_byte_signature_search.sv]
// Top level: byte window chain, match reduction, offset counter and result register.
// A result is presented in the cycle after a beat that completes a match or ends the image.
// Throughput: one byte per cycle unless stalled; the compare across all window cells is one
// combinational reduction. Asynchronous active-low reset clears the window flags, byte count
// and result register, sets the signature to all zero with length 1; no clearing pass.
module wildcard_byte_signature_search
  import wbss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,   // last_byte
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OffsetBits-1:0] m_axis_tdata,   // [31:0] match_offset
  output logic                  m_axis_tuser,   // found
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i
);

  cell_cfg_t             cell_cfg [MaxPattern];
  logic [LenW-1:0]       len;
  logic [7:0]            chain_byte  [MaxPattern+1];
  logic [MaxPattern:0]   chain_valid;
  logic [MaxPattern-1:0] ok;
  logic                  acc;
  logic                  hit;
  logic                  emit;
  logic [OffsetBits-1:0] count_q;
  logic [OffsetBits-1:0] start;
  logic                  reported_q;
  logic                  out_valid_q;
  logic                  out_found_q;
  logic [OffsetBits-1:0] out_offset_q;

  wbss_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cell_cfg_o (cell_cfg),
    .len_o      (len)
  );

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign acc           = s_axis_tvalid && s_axis_tready;

  // Window chain: the new beat enters cell 0, each cell feeds the next
  assign chain_byte[0]  = s_axis_tdata;
  assign chain_valid[0] = 1'b1;

  for (genvar k = 0; k < MaxPattern; k++) begin : g_cell
    wbss_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (acc),
      .clear_i (s_axis_tlast),
      .byte_i  (chain_byte[k]),
      .valid_i (chain_valid[k]),
      .cfg_i   (cell_cfg[k]),
      .byte_o  (chain_byte[k+1]),
      .valid_o (chain_valid[k+1]),
      .ok_o    (ok[k])
    );
  end

  // Match and result decision
  assign hit   = (&ok) && !reported_q;
  assign emit  = hit || (s_axis_tlast && !reported_q);
  assign start = count_q + OffsetBits'(1) - OffsetBits'(len);

  // Byte count and per-image reported flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      reported_q <= 1'b0;
    end else if (acc) begin
      if (s_axis_tlast) begin
        count_q    <= '0;
        reported_q <= 1'b0;
      end else begin
        count_q    <= count_q + OffsetBits'(1);
        reported_q <= reported_q || hit;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && emit) begin
      out_found_q  <= hit;
      out_offset_q <= hit ? start : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_offset_q;
  assign m_axis_tuser  = out_found_q;

`ifndef SYNTH
  // A not-found beat carries a zero offset
  a_nf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_found_q) |-> (out_offset_q == '0))
    else $error("not-found result with nonzero offset");

  // Once reported, later beats of the image give no result
  a_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && reported_q) |=> !out_valid_q)
    else $error("result after image already reported");

  // End of image empties the window and restarts the count
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && s_axis_tlast) |=> ((chain_valid[MaxPattern:1] == '0) && (count_q == '0)
                               && !reported_q))
    else $error("state not cleared after last beat");

  // Every image end gives a result unless one was already given
  a_last_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && s_axis_tlast && !reported_q) |=> out_valid_q)
    else $error("image ended without a result");
`endif

endmodule

[sim/signature_hit_checker.sv]
// Checker for the signature search: tracks the signature, predicts each image result, compares.
module signature_hit_checker
  import wbss_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [7:0] data_byte
  input  logic                  s_axis_tlast,   // last_byte
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OffsetBits-1:0] m_axis_tdata,   // [31:0] match_offset
  input  logic                  m_axis_tuser,   // found
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_idx_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output int unsigned           fail_count_o,
  output int unsigned           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                  found;
    logic [OffsetBits-1:0] offset;
  } image_result_t;

  // Results still owed by the block, oldest first
  image_result_t results_due[$];
  int unsigned   fails = 0;

  // Signature as programmed
  logic [PatBits-1:0] sig_q;
  logic [31:0]        wild_q;
  logic [LenW-1:0]    len_q;

  // Scan state of the current image
  logic [7:0]            window_q [MaxPattern];
  logic [OffsetBits-1:0] count_q;
  logic                  reported_q;
  int unsigned           fill_q;

  assign fail_count_o = fails;

  always @(posedge clk_i or negedge rst_ni) begin : scan
    int unsigned           eff;
    int unsigned           j;
    int unsigned           k;
    logic                  hit;
    logic [OffsetBits-1:0] pos;
    image_result_t         due;
    if (!rst_ni) begin
      sig_q      = '0;
      wild_q     = '0;
      len_q      = LenW'(1);
      count_q    = '0;
      reported_q = 1'b0;
      fill_q     = 0;
      for (k = 0; k < MaxPattern; k++) window_q[k] = 8'h00;
      results_due.delete();
      pending_o <= 0;
    end else begin
      // returned beat against the oldest result due
      if (m_axis_tvalid && m_axis_tready) begin
        if (results_due.size() == 0) begin
          $error("unexpected result beat: found %0d, match_offset %0d",
                 m_axis_tuser, m_axis_tdata);
          fails++;
        end else begin
          due = results_due.pop_front();
          if (m_axis_tuser !== due.found) begin
            $error("found: expected %0d, actual %0d", due.found, m_axis_tuser);
            fails++;
          end
          if (m_axis_tdata !== due.offset) begin
            $error("match_offset: expected %0d, actual %0d", due.offset, m_axis_tdata);
            fails++;
          end
        end
      end

      // register writes; unknown indexes are dropped
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegPat0: sig_q[0   +: 64] = cfg_data_i;
          RegPat1: sig_q[64  +: 64] = cfg_data_i;
          RegPat2: sig_q[128 +: 64] = cfg_data_i;
          RegPat3: sig_q[192 +: 64] = cfg_data_i;
          RegMask: wild_q = cfg_data_i[31:0];
          RegLen:  len_q  = cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end

      // accepted image byte: shift window, try the match ending here
      if (s_axis_tvalid && s_axis_tready) begin
        eff = len_q;
        if (eff == 0) begin
          eff = 1;
        end else if (eff > MaxPattern) begin
          eff = MaxPattern;
        end
        pos = count_q;
        for (k = MaxPattern - 1; k > 0; k--) window_q[k] = window_q[k-1];
        window_q[0] = s_axis_tdata;
        if (fill_q < MaxPattern) fill_q++;
        count_q++;
        // window must hold eff bytes of this image before it can match
        if (!reported_q && fill_q >= eff) begin
          hit = 1'b1;
          for (j = 0; j < eff; j++) begin
            if (!wild_q[j] && window_q[eff-1-j] != sig_q[8*j +: 8]) hit = 1'b0;
          end
          if (hit) begin
            results_due.insert(results_due.size(),
                               image_result_t'{1'b1, OffsetBits'(pos + 1 - eff)});
            reported_q = 1'b1;
          end
        end
        // end of image: report a miss if nothing was reported, then start afresh
        if (s_axis_tlast) begin
          if (!reported_q) begin
            results_due.insert(results_due.size(), image_result_t'{1'b0, '0});
          end
          count_q    = '0;
          reported_q = 1'b0;
          fill_q     = 0;
          for (k = 0; k < MaxPattern; k++) window_q[k] = 8'h00;
        end
      end
      pending_o <= results_due.size();
    end
  end

endmodule

[sim/testbench.sv]
// Testbench top: clock, reset, signature programming and image stimulus, verdict.
module testbench
  import wbss_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // Indexes outside the register map; writes there must change nothing
  localparam logic [CfgIdxW-1:0] RegSpare0 = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpare1 = 3'd7;

  logic                  clk;
  logic                  rst_n;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [7:0]            s_axis_tdata;
  logic                  s_axis_tlast;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OffsetBits-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_we;
  logic [CfgIdxW-1:0]    cfg_idx;
  logic [CfgDataW-1:0]   cfg_data;
  int unsigned           fail_count;
  int unsigned           results_due;

  int unsigned           beats_sent = 0;
  logic                  steady;

  // Stimulus copy of the signature, used to plant matches
  logic [PatBits-1:0]    sig;
  logic [31:0]           wmask;
  logic [LenW-1:0]       plen;
  logic [7:0]            img [512];

  wildcard_byte_signature_search DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  signature_hit_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .fail_count_o  (fail_count),
    .pending_o     (results_due)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // no idling on either side for a stretch in the middle of the run
  assign steady = (beats_sent >= 700) && (beats_sent < 1000);

  // result side back-pressure
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 38);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // program all registers, plus junk at the spare indexes
  task automatic load_signature(input logic [PatBits-1:0] s, input logic [31:0] m,
                                input logic [63:0] lraw);
    sig   = s;
    wmask = m;
    plen  = lraw[LenW-1:0];
    write_reg(RegPat0, s[0   +: 64]);
    write_reg(RegSpare0, {$urandom, $urandom});
    write_reg(RegPat1, s[64  +: 64]);
    write_reg(RegPat2, s[128 +: 64]);
    write_reg(RegPat3, s[192 +: 64]);
    write_reg(RegMask, {$urandom, m});
    write_reg(RegLen, lraw);
    write_reg(RegSpare1, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  // one byte beat, with random gaps ahead of it; tvalid stays up after acceptance
  task automatic send_byte(input logic [7:0] b, input logic l);
    while (!steady && $urandom_range(99) < 38) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
  endtask

  task automatic send_image(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) send_byte(img[i], i == n - 1);
  endtask

  // drain: every owed result back, then wait for the block to go quiet
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin : stimulus
    int unsigned        ph;
    int unsigned        n;
    int unsigned        at;
    int unsigned        i;
    int unsigned        j;
    int unsigned        eff;
    int unsigned        stop_at;
    int unsigned        phase_end;
    logic               narrow;
    logic [PatBits-1:0] rs;
    logic [31:0]        rm;
    logic [63:0]        lraw;
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'h00;
    s_axis_tlast  <= 1'b0;
    m_axis_tready <= 1'b0;
    cfg_we        <= 1'b0;
    cfg_idx       <= RegPat0;
    cfg_data      <= '0;
    sig   = '0;
    wmask = '0;
    plen  = LenW'(1);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset signature: one zero byte; match lands on the last byte, then a miss
    img[0] = 8'hFF; img[1] = 8'h00;
    send_image(2);
    img[0] = 8'hFF;
    send_image(1);
    settle();

    // length zero acts as one; one-byte image that matches, then a miss
    load_signature(PatBits'(8'hAB), 32'h0, 64'h0);
    img[0] = 8'hAB;
    send_image(1);
    img[0] = 8'h00; img[1] = 8'h7F;
    send_image(2);
    settle();

    // leading wildcard, length in the low bits only; later bytes after a hit are silent
    load_signature(PatBits'(24'h33_22_11), 32'h1, 64'hFFFF_FFFF_FFFF_FFC3);
    img[0] = 8'h55; img[1] = 8'h22; img[2] = 8'h33; img[3] = 8'h00; img[4] = 8'h22;
    send_image(5);
    img[0] = 8'h22; img[1] = 8'h33;
    send_image(2);
    img[0] = 8'h80; img[1] = 8'h22; img[2] = 8'h33;
    send_image(3);
    settle();

    // oversized length clamps to the maximum; all wildcards, image too short to match
    for (i = 0; i < 8; i++) rs[32*i +: 32] = $urandom;
    load_signature(rs, 32'hFFFF_FFFF, 64'd63);
    img[0] = 8'h00; img[1] = 8'hFF; img[2] = 8'h5A; img[3] = 8'hA5; img[4] = 8'h01;
    send_image(5);
    settle();

    // random phases: fresh signature each time, then images with planted matches
    stop_at = beats_sent + 2000;
    ph = 0;
    while (beats_sent < stop_at) begin
      for (i = 0; i < 8; i++) rs[32*i +: 32] = $urandom;
      lraw = {$urandom, $urandom};
      case (ph % 6)
        0:       lraw[LenW-1:0] = LenW'(MaxPattern);
        1:       lraw[LenW-1:0] = LenW'(1);
        2:       lraw[LenW-1:0] = '0;
        3:       lraw[LenW-1:0] = LenW'($urandom_range(63, 33));
        default: lraw[LenW-1:0] = LenW'($urandom_range(16, 2));
      endcase
      case ($urandom_range(3))
        0:       rm = '0;
        1:       rm = '1;
        2:       rm = $urandom & $urandom & $urandom;
        default: rm = $urandom;
      endcase
      load_signature(rs, rm, lraw);
      eff = (plen == 0) ? 1 : ((plen > MaxPattern) ? MaxPattern : plen);

      phase_end = beats_sent + 220;
      while (beats_sent < phase_end && beats_sent < stop_at) begin
        n = ($urandom_range(9) == 0) ? $urandom_range(300, 100) : $urandom_range(60, 1);
        // background: either noise or bytes drawn from the signature itself
        narrow = $urandom_range(1);
        for (i = 0; i < n; i++) begin
          j = $urandom_range(eff - 1);
          img[i] = narrow ? sig[8*j +: 8] : 8'($urandom);
        end
        // plant a copy, sometimes flush with the end, sometimes cut off by it
        if ($urandom_range(3) != 0) begin
          at = $urandom_range(n - 1);
          if ($urandom_range(3) == 0 && n >= eff) at = n - eff;
          for (j = 0; j < eff && at + j < n; j++) begin
            img[at+j] = wmask[j] ? 8'($urandom) : sig[8*j +: 8];
          end
          // spoil one fixed byte of the copy now and then
          if ($urandom_range(3) == 0) begin
            j = $urandom_range(eff - 1);
            if (at + j < n && !wmask[j]) img[at+j] ^= 8'($urandom_range(255, 1));
          end
        end
        send_image(n);
      end
      settle();
      ph++;
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
rtl/wbss_pkg.sv
rtl/wbss_cfg.sv
rtl/wbss_cell.sv
rtl/wildcard_byte_signature_search.sv
sim/signature_hit_checker.sv
sim/testbench.sv
